>>> rtl/core/spi_bps_pkg.sv
// Shared types, constants and divisor table for the SPI baud prescaler search.
package spi_bps_pkg;

   // Field and datapath widths.
   localparam int BaudW     = 32;
   localparam int RateW     = 30;
   localparam int ScalerW   = 4;
   localparam int PrescaleW = 2;
   localparam int PairW     = ScalerW + PrescaleW;
   localparam int PairCount = 1 << PairW;
   localparam int DivisorW  = 18;
   localparam int StepW     = 5;

   localparam logic [BaudW-1:0] ModuleClockReset = 32'd50000000;
   localparam logic [BaudW-1:0] ErrInit          = 32'hFFFF_FFFF;

   typedef logic [DivisorW-1:0] divisor_type;
   typedef divisor_type div_tab_type [PairCount];

   // Builds the product scaler * prescaler for every pair at elaboration.
   // The pair index holds the scaler index above the prescaler index.
   function automatic div_tab_type build_div_tab();
      div_tab_type tab;
      int          scaler_tab [16];
      int          prescale_tab [4];
      scaler_tab = '{2, 4, 6, 8, 16, 32, 64, 128, 256, 512, 1024, 2048,
                     4096, 8192, 16384, 32768};
      prescale_tab = '{2, 3, 5, 7};
      for (int s = 0; s < 16; s++) begin
         for (int p = 0; p < 4; p++) begin
            tab[s*4 + p] = DivisorW'(scaler_tab[s] * prescale_tab[p]);
         end
      end
      return tab;
   endfunction

   localparam div_tab_type DivTab = build_div_tab();

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EVAL,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic div_step;
      logic eval;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_last;
      logic exact_hit;
      logic pair_last;
   } sts_type;

endpackage

>>> rtl/core/spi_bps_cfg_top_placeholder.sv
// Top level of the SPI baud prescaler search: controller and datapath.
//
// Usage: a request transaction carries the desired bit rate on req_desired_baud
// and is taken when req_valid is high and req_stall is low. The block then
// tries the scaler/prescaler pairs in order, scaler outer and prescaler inner,
// dividing the module clock by each pair's product on one shared restoring
// divider that retires one quotient bit per cycle. Each pair is divided and
// then evaluated, and up to 64 pairs are tried: the search ends at the first
// exact pair or after the last one. The response is then loaded into the
// output register, after which the block returns to idle and can take the
// next request; req_stall is low only while the block is idle.
// The response sits in an output register with rsp_valid; the receiver may
// hold rsp_stall high as long as it likes, and the payload stays unchanged.
// A new request may be taken while that response still waits; its search
// then pauses at the end until the output register is free.
// The module clock register is written through csr_we/csr_wdata; the user
// must write it only while idle, which the block itself does not enforce.
// Synchronous reset sets the module clock to 50 MHz, empties the output
// register and returns the controller to idle.
module spi_baud_prescaler_search (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [spi_bps_pkg::BaudW-1:0]         csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [spi_bps_pkg::BaudW-1:0]         req_desired_baud,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [spi_bps_pkg::ScalerW-1:0]       rsp_scaler_index,
   output logic [spi_bps_pkg::PrescaleW-1:0]     rsp_prescaler_index,
   output logic [spi_bps_pkg::RateW-1:0]         rsp_achieved_baud,
   output logic                                  rsp_exact_match,
   output logic                                  rsp_above_desired
);
   import spi_bps_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   spi_bps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Divider and search registers.
   spi_bps_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_desired_baud    (req_desired_baud),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_scaler_index    (rsp_scaler_index),
      .rsp_prescaler_index (rsp_prescaler_index),
      .rsp_achieved_baud   (rsp_achieved_baud),
      .rsp_exact_match     (rsp_exact_match),
      .rsp_above_desired   (rsp_above_desired)
   );

endmodule

>>> rtl/core/spi_bps_dp.sv
// Datapath: clock register, shared radix-2 divider, best-pair tracking and result register.
module spi_bps_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [spi_bps_pkg::BaudW-1:0]         csr_wdata,
   input  logic [spi_bps_pkg::BaudW-1:0]         req_desired_baud,
   input  spi_bps_pkg::cmd_type                  cmd,
   output spi_bps_pkg::sts_type                  sts,
   output logic [spi_bps_pkg::ScalerW-1:0]       rsp_scaler_index,
   output logic [spi_bps_pkg::PrescaleW-1:0]     rsp_prescaler_index,
   output logic [spi_bps_pkg::RateW-1:0]         rsp_achieved_baud,
   output logic                                  rsp_exact_match,
   output logic                                  rsp_above_desired
);
   import spi_bps_pkg::*;

   logic [BaudW-1:0]     clk_hz_ff, clk_hz_in;
   logic [BaudW-1:0]     want_ff, want_in;
   logic [BaudW-1:0]     num_ff, num_in;
   logic [DivisorW-1:0]  rem_ff, rem_in;
   logic [StepW-1:0]     step_ff, step_in;
   logic [PairW-1:0]     pair_ff, pair_in;
   logic [BaudW-1:0]     best_err_ff, best_err_in;
   logic [PairW-1:0]     best_pair_ff, best_pair_in;
   logic [BaudW-1:0]     best_q_ff, best_q_in;
   logic [ScalerW-1:0]   out_s_ff, out_s_in;
   logic [PrescaleW-1:0] out_p_ff, out_p_in;
   logic [RateW-1:0]     out_rate_ff, out_rate_in;
   logic                 out_exact_ff, out_exact_in;
   logic                 out_above_ff, out_above_in;

   divisor_type          divisor;
   logic [DivisorW:0]    trial;
   logic [DivisorW:0]    trial_diff;
   logic                 q_bit;
   logic [BaudW-1:0]     err;

   // Module clock register, written through the configuration port.
   always_comb begin
      clk_hz_in = csr_we ? csr_wdata : clk_hz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= ModuleClockReset;
      end else begin
         clk_hz_ff <= clk_hz_in;
      end
   end

   // One restoring division step: shift in the next dividend bit and subtract if it fits.
   assign divisor    = DivTab[pair_ff];
   assign trial      = {rem_ff, num_ff[BaudW-1]};
   assign trial_diff = trial - {1'b0, divisor};
   assign q_bit      = (trial >= {1'b0, divisor});

   // Absolute error of the finished quotient against the request.
   assign err = (num_ff >= want_ff) ? (num_ff - want_ff) : (want_ff - num_ff);

   assign sts.div_last  = (step_ff == StepW'(BaudW - 1));
   assign sts.exact_hit = (num_ff == want_ff);
   assign sts.pair_last = (pair_ff == PairW'(PairCount - 1));

   // Search state next values.
   always_comb begin
      want_in      = want_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      pair_in      = pair_ff;
      best_err_in  = best_err_ff;
      best_pair_in = best_pair_ff;
      best_q_in    = best_q_ff;

      if (cmd.start) begin
         want_in      = req_desired_baud;
         num_in       = clk_hz_ff;
         rem_in       = '0;
         step_in      = '0;
         pair_in      = '0;
         best_err_in  = ErrInit;
         best_pair_in = '0;
         best_q_in    = '0;
      end else if (cmd.div_step) begin
         num_in  = {num_ff[BaudW-2:0], q_bit};
         rem_in  = q_bit ? trial_diff[DivisorW-1:0] : trial[DivisorW-1:0];
         step_in = step_ff + 1'b1;
      end else if (cmd.eval) begin
         // An exact hit or a strictly smaller error takes the current pair.
         if (sts.exact_hit || (err < best_err_ff)) begin
            best_err_in  = err;
            best_pair_in = pair_ff;
            best_q_in    = num_ff;
         end
         pair_in = pair_ff + 1'b1;
         num_in  = clk_hz_ff;
         rem_in  = '0;
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      want_ff      <= want_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      pair_ff      <= pair_in;
      best_err_ff  <= best_err_in;
      best_pair_ff <= best_pair_in;
      best_q_ff    <= best_q_in;
   end

   // Result register, loaded when the controller hands the transaction out.
   always_comb begin
      out_s_in     = out_s_ff;
      out_p_in     = out_p_ff;
      out_rate_in  = out_rate_ff;
      out_exact_in = out_exact_ff;
      out_above_in = out_above_ff;
      if (cmd.load_out) begin
         out_s_in     = best_pair_ff[PairW-1:PrescaleW];
         out_p_in     = best_pair_ff[PrescaleW-1:0];
         out_rate_in  = best_q_ff[RateW-1:0];
         out_exact_in = (best_q_ff == want_ff);
         out_above_in = (best_q_ff > want_ff);
      end
   end

   always_ff @(posedge clock) begin
      out_s_ff     <= out_s_in;
      out_p_ff     <= out_p_in;
      out_rate_ff  <= out_rate_in;
      out_exact_ff <= out_exact_in;
      out_above_ff <= out_above_in;
   end

   assign rsp_scaler_index    = out_s_ff;
   assign rsp_prescaler_index = out_p_ff;
   assign rsp_achieved_baud   = out_rate_ff;
   assign rsp_exact_match     = out_exact_ff;
   assign rsp_above_desired   = out_above_ff;

endmodule

>>> rtl/core/spi_bps_ctrl.sv
// Controller: sequences up to 64 divisions and the handshakes of both channels.
module spi_bps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  spi_bps_pkg::sts_type sts,
   output spi_bps_pkg::cmd_type cmd
);
   import spi_bps_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new transaction when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.exact_hit || sts.pair_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and commands.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         ST_DONE: begin
            cmd.load_out = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
